// ----- rtl/core/plst_pkg.sv -----
`default_nettype none

package plst_pkg;

  localparam int DEPTH_DEF  = 16;
  localparam int DATA_W_DEF = 32;
  localparam int POS_W      = 5;
  localparam int CNT_OUT_W  = 5;
  localparam int RV_W       = 32;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_MODIFY = 2'd1,
    OP_REMOVE = 2'd2,
    OP_READ   = 2'd3
  } plst_op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } plst_status_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;
    logic rem;
    logic wr;
  } plst_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/core/plst_cell.sv -----
`default_nettype none

module plst_cell #(
  parameter int IDX    = 0,
  parameter int CMP_W  = 5,
  parameter int DATA_W = 32
) (
  input  wire                    clk,
  input  wire plst_pkg::plst_cmd_t cmd_i,
  input  wire [CMP_W-1:0]        pos_i,
  input  wire [DATA_W-1:0]       value_i,
  input  wire [DATA_W-1:0]       left_i,
  input  wire [DATA_W-1:0]       right_i,
  output logic [DATA_W-1:0]      data_o,
  output logic [DATA_W-1:0]      rd_o
);
  import plst_pkg::*;

  localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(IDX);

  logic [DATA_W-1:0] data_r;
  logic [DATA_W-1:0] data_nxt;
  logic              hit;
  logic              after;

  assign hit   = (pos_i == MY_IDX);
  assign after = (pos_i < MY_IDX);

  always_comb begin
    data_nxt = data_r;
    if (cmd_i.ins) begin
      if (hit) begin
        data_nxt = value_i;
      end else if (after) begin
        data_nxt = left_i;
      end
    end else if (cmd_i.rem) begin
      if (hit || after) begin
        data_nxt = right_i;
      end
    end else if (cmd_i.wr && hit) begin
      data_nxt = value_i;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o = data_r;
  assign rd_o   = hit ? data_r : '0;

endmodule

`default_nettype wire

// ----- rtl/core/positional_list_engine_core.sv -----
// positional list engine: a row of cells, one list entry each, that shift together
// result: strobed in the cycle after the word is accepted
// throughput: one word per cycle, busy never rises; the whole row updates at the accepting edge
// reset: entry count cleared, strobe low; cell contents are not reset
// the receiver cannot stall, each result is shown for exactly one cycle
`default_nettype none

module positional_list_engine_core #(
  parameter int DEPTH  = plst_pkg::DEPTH_DEF,
  parameter int DATA_W = plst_pkg::DATA_W_DEF
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             start,
  output logic                            busy,
  input  wire [1:0]                       in_operation,
  input  wire [plst_pkg::POS_W-1:0]       in_position,
  input  wire signed [31:0]               in_value,
  output logic                            out_strobe,
  output logic signed [plst_pkg::RV_W-1:0] out_read_value,
  output logic [plst_pkg::CNT_OUT_W-1:0]  out_count,
  output logic [1:0]                      out_status
);
  import plst_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int EXT_W = (CMP_W > CNT_OUT_W) ? CMP_W : CNT_OUT_W;

  logic              accept;
  plst_op_t          op;
  logic [CMP_W-1:0]  pos;
  logic [CMP_W-1:0]  cnt;
  logic [DATA_W-1:0] val;
  logic [DATA_W+31:0] val_ext;

  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  cnt_nxt;
  plst_status_t      st;
  plst_cmd_t         cmd;

  logic [DATA_W-1:0] cell_data [DEPTH];
  logic [DATA_W-1:0] cell_rd   [DEPTH];
  logic [DATA_W-1:0] rd_or;
  logic [RV_W+DATA_W-1:0] rd_ext;
  logic [RV_W-1:0]   rv;
  logic [EXT_W-1:0]  cnt_out_ext;

  logic              out_strobe_r;
  logic [RV_W-1:0]   out_read_value_r;
  logic [CNT_OUT_W-1:0] out_count_r;
  plst_status_t      out_status_r;

  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign op      = plst_op_t'(in_operation);
  assign pos     = CMP_W'(in_position);
  assign cnt     = CMP_W'(cnt_r);
  assign val_ext = {{DATA_W{1'b0}}, in_value};
  assign val     = val_ext[DATA_W-1:0];

  always_comb begin
    st      = ST_OK;
    cmd     = '0;
    cnt_nxt = cnt_r;
    case (op)
      OP_INSERT: begin
        if (cnt_r == CNT_W'(DEPTH)) begin
          st = ST_FULL;
        end else if (pos > cnt) begin
          st = ST_RANGE;
        end else begin
          cmd.ins = accept;
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      OP_MODIFY: begin
        if (pos >= cnt) begin
          st = ST_RANGE;
        end else begin
          cmd.wr = accept;
        end
      end
      OP_REMOVE: begin
        if (cnt_r == '0) begin
          st = ST_EMPTY;
        end else if (pos >= cnt) begin
          st = ST_RANGE;
        end else begin
          cmd.rem = accept;
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      OP_READ: begin
        if (pos >= cnt) begin
          st = ST_RANGE;
        end
      end
      default: begin
        st = ST_OK;
      end
    endcase
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] left;
    logic [DATA_W-1:0] right;
    if (i == 0) begin : g_first
      assign left = val;
    end else begin : g_mid
      assign left = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right = cell_data[i];
    end else begin : g_inner
      assign right = cell_data[i+1];
    end
    plst_cell #(
      .IDX    (i),
      .CMP_W  (CMP_W),
      .DATA_W (DATA_W)
    ) u_cell (
      .clk     (clk),
      .cmd_i   (cmd),
      .pos_i   (pos),
      .value_i (val),
      .left_i  (left),
      .right_i (right),
      .data_o  (cell_data[i]),
      .rd_o    (cell_rd[i])
    );
  end

  always_comb begin
    rd_or = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_or = rd_or | cell_rd[i];
    end
  end

  assign rd_ext      = {{RV_W{1'b0}}, rd_or};
  assign rv          = (op == OP_READ && st == ST_OK) ? rd_ext[RV_W-1:0] : '0;
  assign cnt_out_ext = EXT_W'(cnt_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= accept;
      if (accept) begin
        cnt_r <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_read_value_r <= rv;
      out_count_r      <= cnt_out_ext[CNT_OUT_W-1:0];
      out_status_r     <= st;
    end
  end

  assign out_strobe     = out_strobe_r;
  assign out_read_value = out_read_value_r;
  assign out_count      = out_count_r;
  assign out_status     = out_status_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("entry count beyond depth");

  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_strobe)
    else $error("accepted word gave no result");

  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_status_r == ST_FULL |-> cnt_r == CNT_W'(DEPTH))
    else $error("full status with room left");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_status_r == ST_EMPTY |-> cnt_r == '0)
    else $error("empty status on non-empty list");

endmodule

`default_nettype wire
